[design/bip39_entropy_word_encoder_macros.svh]
// Assertion macros for the entropy word encoder.
`ifndef BIP39_ENTROPY_WORD_ENCODER_MACROS_SVH
`define BIP39_ENTROPY_WORD_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define BIP_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("implication check failed");
`define BIP_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BIP_ASSERT_IMP(lbl, ant, cons)
`define BIP_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

[design/bip39_pkg.sv]
package bip39_pkg;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_HASH,
    S_FINISH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       wide;
    logic       load_byte;
    logic       init;
    logic       round;
    logic [5:0] round_idx;
    logic       finish;
    logic       emit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  localparam logic [5:0] NEED_NARROW  = 6'd16;
  localparam logic [5:0] NEED_WIDE    = 6'd32;
  localparam logic [4:0] WORDS_NARROW = 5'd12;
  localparam logic [4:0] WORDS_WIDE   = 5'd24;
  localparam int         IDX_W        = 11;
  localparam logic [7:0] CK_MASK_NARROW = 8'hF0;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] sha_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

[design/bip39_ctrl.sv]
`include "bip39_entropy_word_encoder_macros.svh"

module bip39_ctrl #(
  parameter int MAX_ENTROPY_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_word_count_mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  bip39_pkg::sts_t   sts,
  output bip39_pkg::cmd_t   cmd
);

  bip39_pkg::state_t state_r, state_nxt;
  logic       mode_r;
  logic [5:0] bytes_r;
  logic [5:0] rnd_r;
  logic [4:0] words_r;
  logic       wide;
  logic [5:0] need;
  logic [4:0] nwords;

  assign wide   = mode_r && (MAX_ENTROPY_BYTES >= 32);
  assign need   = wide ? bip39_pkg::NEED_WIDE : bip39_pkg::NEED_NARROW;
  assign nwords = wide ? bip39_pkg::WORDS_WIDE : bip39_pkg::WORDS_NARROW;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bip39_pkg::S_LOAD: begin
        if (in_valid && (bytes_r + 6'd1 == need)) state_nxt = bip39_pkg::S_INIT;
      end
      bip39_pkg::S_INIT: state_nxt = bip39_pkg::S_HASH;
      bip39_pkg::S_HASH: begin
        if (rnd_r == 6'd63) state_nxt = bip39_pkg::S_FINISH;
      end
      bip39_pkg::S_FINISH: state_nxt = bip39_pkg::S_EMIT;
      bip39_pkg::S_EMIT: begin
        if (sts.out_free && (words_r + 5'd1 == nwords)) state_nxt = bip39_pkg::S_LOAD;
      end
      default: state_nxt = bip39_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.wide      = wide;
    cmd.round_idx = rnd_r;
    in_stall      = 1'b1;
    unique case (state_r)
      bip39_pkg::S_LOAD: begin
        in_stall      = 1'b0;
        cmd.load_byte = in_valid;
      end
      bip39_pkg::S_INIT:   cmd.init   = 1'b1;
      bip39_pkg::S_HASH:   cmd.round  = 1'b1;
      bip39_pkg::S_FINISH: cmd.finish = 1'b1;
      bip39_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.last = (words_r + 5'd1 == nwords);
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bip39_pkg::S_LOAD;
      mode_r  <= 1'b0;
      bytes_r <= '0;
      rnd_r   <= '0;
      words_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r  <= cfg_word_count_mode;
        bytes_r <= '0;
      end else if (cmd.init) begin
        bytes_r <= '0;
      end else if (cmd.load_byte) begin
        bytes_r <= bytes_r + 6'd1;
      end
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.finish) words_r <= '0;
      if (cmd.emit) words_r <= words_r + 5'd1;
    end
  end

  `BIP_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
  `BIP_ASSERT_NXT(a_hash_end, (state_r == bip39_pkg::S_HASH) && (rnd_r == 6'd63),
                  (state_r == bip39_pkg::S_FINISH) && (rnd_r == 6'd0))
  `BIP_ASSERT_IMP(a_words_bound, state_r == bip39_pkg::S_EMIT, words_r < nwords)
  `BIP_ASSERT_IMP(a_bytes_bound, state_r == bip39_pkg::S_LOAD, bytes_r < need)

endmodule

[design/bip39_dp.sv]
module bip39_dp #(
  parameter int MAX_ENTROPY_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bip39_pkg::cmd_t                cmd,
  output bip39_pkg::sts_t                sts,
  input  logic [7:0]                     in_entropy_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bip39_pkg::IDX_W-1:0]    out_word_index,
  output logic                           out_last
);

  localparam int SW  = MAX_ENTROPY_BYTES * 8;
  localparam int SRW = SW + 8;

  logic [SW-1:0]  ent_r;
  logic [255:0]   ent256;
  logic [511:0]   blk;
  logic [31:0]    w_r [16];
  logic [31:0]    v_r [8];
  logic [31:0]    w_next, x1, x2;
  logic [SRW-1:0] sr_r;
  logic [7:0]     ck;
  logic           out_valid_r;
  logic [bip39_pkg::IDX_W-1:0] idx_r;
  logic           last_r;

  assign ent256 = 256'(ent_r);
  assign blk = cmd.wide ? {ent256, 32'h80000000, 192'b0, 32'd256}
                        : {ent256[127:0], 32'h80000000, 320'b0, 32'd128};

  assign w_next = w_r[0] + bip39_pkg::ssig0(w_r[1]) + w_r[9] + bip39_pkg::ssig1(w_r[14]);
  assign x1 = v_r[7] + bip39_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + bip39_pkg::sha_k(cmd.round_idx) + w_r[0];
  assign x2 = bip39_pkg::bsig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign ck = 8'((v_r[0] + bip39_pkg::SHA_IV[255:224]) >> 24);

  always_ff @(posedge clk) begin
    if (cmd.load_byte) ent_r <= {ent_r[SW-9:0], in_entropy_byte};
    if (cmd.init) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= bip39_pkg::SHA_IV[255 - 32*i -: 32];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_next;
      for (int i = 1; i < 8; i++) begin
        if (i != 4) v_r[i] <= v_r[i-1];
      end
      v_r[4] <= v_r[3] + x1;
      v_r[0] <= x1 + x2;
    end
    if (cmd.finish) begin
      if (cmd.wide) sr_r <= SRW'({ent256[255 -: SW], ck});
      else sr_r <= SRW'({ent_r[127:0], ck & bip39_pkg::CK_MASK_NARROW}) << (SRW - 136);
    end
    if (cmd.emit) begin
      sr_r  <= sr_r << bip39_pkg::IDX_W;
      idx_r <= sr_r[SRW-1 -: bip39_pkg::IDX_W];
      last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_word_index = idx_r;
  assign out_last       = last_r;

endmodule

[design/bip39_entropy_word_encoder.sv]
// Flow: after the last entropy byte come the schedule load, 64 SHA-256 rounds
// on one shared round unit, the checksum fold and the output register.
// Throughput: one byte per cycle while loading, then one word per cycle while
// out_stall allows it; no new bytes are taken until the last word is emitted.
// Reset: synchronous active-low rst_n clears control state and selects 12 words.
module bip39_entropy_word_encoder #(
  parameter int MAX_ENTROPY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_word_count_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_entropy_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_word_index,
  output logic        out_last
);

  // Command and status between the sequencer and the hash/emit datapath.
  bip39_pkg::cmd_t cmd;
  bip39_pkg::sts_t sts;

  // Sequencer: counts bytes, rounds and emitted words; a config write drops
  // any partial load.
  bip39_ctrl #(.MAX_ENTROPY_BYTES(MAX_ENTROPY_BYTES)) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_word_count_mode (cfg_word_count_mode),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .sts                 (sts),
    .cmd                 (cmd)
  );

  // Datapath: entropy shift store, rolling message schedule, round unit,
  // and the 11-bit slicing shifter feeding the output register.
  bip39_dp #(.MAX_ENTROPY_BYTES(MAX_ENTROPY_BYTES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entropy_byte (in_entropy_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_index  (out_word_index),
    .out_last        (out_last)
  );

endmodule

[verif/bip39_entropy_word_encoder_test.sv]
module bip39_entropy_word_encoder_test;

  // Mode register codes.
  localparam logic MODE_12_WORDS = 1'b0;
  localparam logic MODE_24_WORDS = 1'b1;

  // Byte patterns for a load.
  localparam int PAT_ZERO = 0;
  localparam int PAT_ONES = 1;
  localparam int PAT_ALT  = 2;
  localparam int PAT_RAND = 3;

  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_LOADS = 7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [10:0] idx;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_word_count_mode = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_entropy_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_word_index;
  logic        out_last;

  // Predictor state: its own copy of the mode and the partial load.
  logic        mode_shadow = MODE_12_WORDS;
  logic [7:0]  load_bytes [33];
  int          load_count = 0;
  word_t       pending_words [$];
  // Typed-in first index per completed load, -1 where only the predictor checks.
  int          typed_first = -1;
  int          first_checks [$];
  bit          at_first = 1'b1;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  // Long receiver hold-off request, served by the receiver process.
  bit  hold_request = 1'b0;

  always #10 clk = ~clk;

  bip39_entropy_word_encoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_word_count_mode (cfg_word_count_mode),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_entropy_byte     (in_entropy_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_word_index      (out_word_index),
    .out_last            (out_last)
  );

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // First digest byte of a single-block SHA-256 over the first n loaded bytes.
  function automatic logic [7:0] checksum_byte(int n);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < n; i++) blk[i] = load_bytes[i];
    blk[n] = 8'h80;
    blk[62] = 8'((n * 8) >> 8);
    blk[63] = 8'(n * 8);
    for (int t = 0; t < 16; t++) w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = HASH_IV[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    return 8'((HASH_IV[0] + v[0]) >> 24);
  endfunction

  // Take one accepted byte; on a complete load, queue the word indices.
  function automatic void predict_words(logic [7:0] b);
    int          need, nwords, have, src;
    logic [23:0] acc;
    logic [7:0]  ck;
    need = (mode_shadow == MODE_24_WORDS) ? 32 : 16;
    nwords = (mode_shadow == MODE_24_WORDS) ? 24 : 12;
    load_bytes[load_count] = b;
    load_count++;
    if (load_count < need) return;
    ck = checksum_byte(need);
    load_bytes[need] = (mode_shadow == MODE_24_WORDS) ? ck : (ck & 8'hF0);
    acc = '0; have = 0; src = 0;
    for (int k = 0; k < nwords; k++) begin
      while (have < 11) begin
        acc = {acc[15:0], load_bytes[src]};
        src++;
        have += 8;
      end
      have -= 11;
      pending_words.push_back('{idx: 11'(acc >> have), last: (k == nwords - 1)});
    end
    first_checks.push_back(typed_first);
    typed_first = -1;
    load_count = 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Directed table: each row is a mode write or a load; a row with an obvious
  // first index carries it typed in.
  typedef struct {
    logic        is_cfg;
    logic        mode;
    int          n;
    int          pattern;
    logic        check_first;
    logic [10:0] first_idx;
  } step_row_t;

  // Send one byte, with a random gap before it; hold the payload while stalled.
  // Valid stays high after the transfer; the next byte or the caller drops it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_entropy_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_words(b);
  endtask

  // Write the mode register once the block is idle: all words out, plus slack
  // for a partial load that produces nothing.
  task automatic write_mode(logic m);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_word_count_mode <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_shadow = m;
    load_count = 0;
  endtask

  task automatic send_load(int n, int pattern);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case (pattern)
        PAT_ZERO: b = 8'h00;
        PAT_ONES: b = 8'hFF;
        PAT_ALT:  b = (i % 2) ? 8'h55 : 8'hAA;
        default:  b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  // Receiver: check each word transfer against the oldest expectation.
  always @(posedge clk) begin
    word_t want;
    int    first_want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_word_index, -1);
      end else begin
        want = pending_words.pop_front();
        if (out_word_index !== want.idx)
          report_mismatch("index", out_word_index, want.idx);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
        if (at_first && first_checks.size() != 0) begin
          first_want = first_checks.pop_front();
          if (first_want >= 0 && out_word_index !== 11'(first_want))
            report_mismatch("first index", out_word_index, first_want);
        end
        at_first = want.last;
      end
    end
  end

  // Receiver stall: random per-word waits, with a long hold-off on request.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        wait_cycles = 300;
        hold_request = 1'b0;
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bip39_entropy_word_encoder_test: FAIL");
      $finish;
    end
  end

  initial begin
    step_row_t dir_rows [11];
    dir_rows = '{
      // All-zero 12-word load; first word is index 0.
      '{1'b0, MODE_12_WORDS, 16, PAT_ZERO, 1'b1, 11'd0},
      // Partial load, then a mode change discards it.
      '{1'b0, MODE_12_WORDS, 5,  PAT_RAND, 1'b0, 11'd0},
      '{1'b1, MODE_24_WORDS, 0,  PAT_RAND, 1'b0, 11'd0},
      // All-ones 24-word load; first word is 2047.
      '{1'b0, MODE_24_WORDS, 32, PAT_ONES, 1'b1, 11'd2047},
      '{1'b0, MODE_24_WORDS, 32, PAT_ALT,  1'b0, 11'd0},
      // Partial wide load discarded by rewriting the same mode.
      '{1'b0, MODE_24_WORDS, 7,  PAT_RAND, 1'b0, 11'd0},
      '{1'b1, MODE_24_WORDS, 0,  PAT_RAND, 1'b0, 11'd0},
      '{1'b0, MODE_24_WORDS, 32, PAT_RAND, 1'b0, 11'd0},
      '{1'b1, MODE_12_WORDS, 0,  PAT_RAND, 1'b0, 11'd0},
      // All-ones 12-word load; first word is 2047.
      '{1'b0, MODE_12_WORDS, 16, PAT_ONES, 1'b1, 11'd2047},
      '{1'b0, MODE_12_WORDS, 16, PAT_ALT,  1'b0, 11'd0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        write_mode(dir_rows[r].mode);
      end else begin
        typed_first = dir_rows[r].check_first ? int'(dir_rows[r].first_idx) : -1;
        send_load(dir_rows[r].n, dir_rows[r].pattern);
      end
    end

    // Pressure: hold the receiver off on the next word out, with a second load queued behind it.
    hold_request = 1'b1;
    send_load(16, PAT_RAND);
    send_load(16, PAT_RAND);

    // Random: mostly complete loads with random bytes, mode switched now
    // and then, some loads cut short by a mode write.
    for (int i = 0; i < RANDOM_LOADS; i++) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        send_load($urandom_range(1, 15), PAT_RAND);
        write_mode(1'($urandom_range(0, 1)));
      end
      send_load((mode_shadow == MODE_24_WORDS) ? 32 : 16, PAT_RAND);
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bip39_entropy_word_encoder_test: PASS");
    end else begin
      $display("bip39_entropy_word_encoder_test: FAIL");
    end
    $finish;
  end

endmodule
